// ===== rtl/wrms_pkg.sv =====
// Shared types and constants for the window RMS unit.
`timescale 1ns / 1ps
`default_nettype none
package wrms_pkg;

  localparam int unsigned WideW  = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned LevelW = 32;
  localparam int unsigned CntW   = 6;

  localparam logic [WideW-1:0] SqrtProbeInit = 64'h4000_0000_0000_0000;
  localparam logic [CntW-1:0]  DivStepsWide  = 6'd63;
  localparam logic [CntW-1:0]  DivStepsNarrow = 6'd31;
  localparam logic [CntW-1:0]  SqrtSteps     = 6'd31;
  localparam logic [CntW-1:0]  MulLastStep   = 6'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT,
    OP_CMP
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/wrms_step.sv =====
// Shared subtract/compare unit: one restoring-divide, root or compare step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wrms_step (
  input  wrms_pkg::op_t                     op,
  input  logic [wrms_pkg::WideW-1:0]        work_i,
  input  logic [wrms_pkg::CountW-1:0]       rem_i,
  input  logic [wrms_pkg::CountW-1:0]       n_i,
  input  logic [wrms_pkg::WideW-1:0]        root_i,
  input  logic [wrms_pkg::WideW-1:0]        probe_i,
  input  logic [wrms_pkg::WideW-1:0]        aux_i,
  output logic [wrms_pkg::WideW-1:0]        work_o,
  output logic [wrms_pkg::CountW-1:0]       rem_o,
  output logic [wrms_pkg::WideW-1:0]        root_o,
  output logic [wrms_pkg::WideW-1:0]        probe_o,
  output logic                              pos_o
);

  logic [wrms_pkg::CountW:0]  rem_sh;
  logic [wrms_pkg::WideW-1:0] trial;
  logic [wrms_pkg::WideW-1:0] op_a;
  logic [wrms_pkg::WideW-1:0] op_b;
  logic [wrms_pkg::WideW:0]   diff;
  logic                       borrow;

  assign rem_sh = {rem_i, work_i[wrms_pkg::WideW-1]};
  // root bits always sit above the probe bit, so the add is an OR
  assign trial  = root_i | probe_i;

  always_comb begin
    unique case (op)
      wrms_pkg::OP_DIV: begin
        op_a = {{(wrms_pkg::WideW-wrms_pkg::CountW-1){1'b0}}, rem_sh};
        op_b = {{(wrms_pkg::WideW-wrms_pkg::CountW){1'b0}}, n_i};
      end
      wrms_pkg::OP_SQRT: begin
        op_a = work_i;
        op_b = trial;
      end
      wrms_pkg::OP_CMP: begin
        op_a = work_i;
        op_b = aux_i;
      end
      default: begin
        op_a = work_i;
        op_b = aux_i;
      end
    endcase
  end

  assign diff   = {1'b0, op_a} - {1'b0, op_b};
  assign borrow = diff[wrms_pkg::WideW];
  assign pos_o  = !borrow && (diff[wrms_pkg::WideW-1:0] != '0);

  always_comb begin
    work_o  = work_i;
    rem_o   = rem_i;
    root_o  = root_i;
    probe_o = probe_i;
    unique case (op)
      wrms_pkg::OP_DIV: begin
        work_o = {work_i[wrms_pkg::WideW-2:0], !borrow};
        rem_o  = borrow ? rem_sh[wrms_pkg::CountW-1:0] : diff[wrms_pkg::CountW-1:0];
      end
      wrms_pkg::OP_SQRT: begin
        if (!borrow) begin
          work_o = diff[wrms_pkg::WideW-1:0];
          root_o = (root_i >> 1) | probe_i;
        end else begin
          root_o = root_i >> 1;
        end
        probe_o = probe_i >> 2;
      end
      wrms_pkg::OP_CMP: begin
        work_o = diff[wrms_pkg::WideW-1:0];
      end
      default: begin
        work_o = work_i;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/window_rms_from_sums_unit.sv =====
// Top level of the window RMS unit: sequencer, multiplier and result register.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | kind, sample_sum, square_total, count
//  out_    | output    | out_valid / out_ready  | rms_level
//
// Plain mode: accept, 64 divide steps, 32 root steps, then the result.
// Centered mode: accept, 5 multiply steps, 1 compare, 32 root steps, 32 divide steps, then the result.
// A zero count or a non-positive centered difference skips the root and divide and gives a zero result.
// The single subtractor in wrms_step is reused by divide, root and compare.
// rst_n is synchronous; it clears the sequencer and the output valid.
// in_ready is high only in idle; a result waiting on out_ready holds the next one in S_DONE.
`timescale 1ns / 1ps
`default_nettype none
module window_rms_from_sums_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [wrms_pkg::WideW-1:0]        in_sample_sum,
  input  logic [wrms_pkg::WideW-1:0]        in_square_total,
  input  logic [wrms_pkg::CountW-1:0]       in_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wrms_pkg::LevelW-1:0]       out_rms_level
);

  localparam int unsigned HalfW = wrms_pkg::WideW / 2;

  wrms_pkg::state_t               state_r, state_nxt;
  logic [wrms_pkg::CntW-1:0]      cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           kind_r, kind_nxt;
  logic                           fin_r, fin_nxt;
  logic [wrms_pkg::WideW-1:0]     s_r, s_nxt;
  logic [wrms_pkg::WideW-1:0]     sq_r, sq_nxt;
  logic [wrms_pkg::CountW-1:0]    n_r, n_nxt;
  logic [wrms_pkg::WideW-1:0]     work_r, work_nxt;
  logic [wrms_pkg::CountW-1:0]    rem_r, rem_nxt;
  logic [wrms_pkg::WideW-1:0]     root_r, root_nxt;
  logic [wrms_pkg::WideW-1:0]     probe_r, probe_nxt;
  logic [wrms_pkg::WideW-1:0]     aux_r, aux_nxt;
  logic [wrms_pkg::WideW-1:0]     prod_r, prod_nxt;
  logic [wrms_pkg::LevelW-1:0]    res_r, res_nxt;
  logic [wrms_pkg::LevelW-1:0]    level_r, level_nxt;

  logic [HalfW-1:0]               mul_a;
  logic [HalfW-1:0]               mul_b;
  logic [wrms_pkg::LevelW-1:0]    round_acc;

  wrms_pkg::op_t                  op;
  logic [wrms_pkg::WideW-1:0]     work_o;
  logic [wrms_pkg::CountW-1:0]    rem_o;
  logic [wrms_pkg::WideW-1:0]     root_o;
  logic [wrms_pkg::WideW-1:0]     probe_o;
  logic                           pos_o;

  wrms_step u_step (
    .op      (op),
    .work_i  (work_r),
    .rem_i   (rem_r),
    .n_i     (n_r),
    .root_i  (root_r),
    .probe_i (probe_r),
    .aux_i   (aux_r),
    .work_o  (work_o),
    .rem_o   (rem_o),
    .root_o  (root_o),
    .probe_o (probe_o),
    .pos_o   (pos_o)
  );

  assign in_ready      = (state_r == wrms_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_rms_level = level_r;

  assign round_acc = root_o[wrms_pkg::LevelW-1:0]
                   + {{(wrms_pkg::LevelW-wrms_pkg::CountW+1){1'b0}},
                      n_r[wrms_pkg::CountW-1:1]};

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin mul_a = sq_r[HalfW-1:0];            mul_b = {{(HalfW-wrms_pkg::CountW){1'b0}}, n_r}; end
      3'd1:    begin mul_a = sq_r[wrms_pkg::WideW-1:HalfW]; mul_b = {{(HalfW-wrms_pkg::CountW){1'b0}}, n_r}; end
      3'd2:    begin mul_a = s_r[HalfW-1:0];             mul_b = s_r[HalfW-1:0]; end
      3'd3:    begin mul_a = s_r[wrms_pkg::WideW-1:HalfW]; mul_b = s_r[HalfW-1:0]; end
      default: begin mul_a = '0;                          mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    fin_nxt       = fin_r;
    s_nxt         = s_r;
    sq_nxt        = sq_r;
    n_nxt         = n_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    probe_nxt     = probe_r;
    aux_nxt       = aux_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    level_nxt     = level_r;
    op            = wrms_pkg::OP_CMP;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      wrms_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          s_nxt    = in_sample_sum;
          sq_nxt   = in_square_total;
          n_nxt    = in_count;
          rem_nxt  = '0;
          fin_nxt  = 1'b0;
          cnt_nxt  = '0;
          if (in_count == '0) begin
            res_nxt   = '0;
            state_nxt = wrms_pkg::S_DONE;
          end else if (in_kind) begin
            state_nxt = wrms_pkg::S_MUL;
          end else begin
            work_nxt  = in_square_total;
            cnt_nxt   = wrms_pkg::DivStepsWide;
            state_nxt = wrms_pkg::S_DIV;
          end
        end
      end
      wrms_pkg::S_MUL: begin
        prod_nxt = mul_a * mul_b;
        case (cnt_r[2:0])
          3'd1: work_nxt = prod_r;
          3'd2: work_nxt[wrms_pkg::WideW-1:HalfW] =
                  work_r[wrms_pkg::WideW-1:HalfW] + prod_r[HalfW-1:0];
          3'd3: aux_nxt = prod_r;
          3'd4: aux_nxt[wrms_pkg::WideW-1:HalfW] =
                  aux_r[wrms_pkg::WideW-1:HalfW] + {prod_r[HalfW-2:0], 1'b0};
          default: ;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == wrms_pkg::MulLastStep) begin
          state_nxt = wrms_pkg::S_CMP;
        end
      end
      wrms_pkg::S_CMP: begin
        op = wrms_pkg::OP_CMP;
        if (pos_o) begin
          work_nxt  = work_o;
          root_nxt  = '0;
          probe_nxt = wrms_pkg::SqrtProbeInit;
          cnt_nxt   = wrms_pkg::SqrtSteps;
          state_nxt = wrms_pkg::S_SQRT;
        end else begin
          res_nxt   = '0;
          state_nxt = wrms_pkg::S_DONE;
        end
      end
      wrms_pkg::S_SQRT: begin
        op        = wrms_pkg::OP_SQRT;
        work_nxt  = work_o;
        root_nxt  = root_o;
        probe_nxt = probe_o;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (kind_r) begin
            work_nxt  = {round_acc, {(wrms_pkg::WideW-wrms_pkg::LevelW){1'b0}}};
            rem_nxt   = '0;
            fin_nxt   = 1'b1;
            cnt_nxt   = wrms_pkg::DivStepsNarrow;
            state_nxt = wrms_pkg::S_DIV;
          end else begin
            res_nxt   = root_o[wrms_pkg::LevelW-1:0];
            state_nxt = wrms_pkg::S_DONE;
          end
        end
      end
      wrms_pkg::S_DIV: begin
        op       = wrms_pkg::OP_DIV;
        work_nxt = work_o;
        rem_nxt  = rem_o;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (fin_r) begin
            res_nxt   = work_o[wrms_pkg::LevelW-1:0];
            state_nxt = wrms_pkg::S_DONE;
          end else begin
            root_nxt  = '0;
            probe_nxt = wrms_pkg::SqrtProbeInit;
            cnt_nxt   = wrms_pkg::SqrtSteps;
            state_nxt = wrms_pkg::S_SQRT;
          end
        end
      end
      wrms_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          level_nxt     = res_r;
          state_nxt     = wrms_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wrms_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrms_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      fin_r       <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    sq_r    <= sq_nxt;
    n_r     <= n_nxt;
    work_r  <= work_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    probe_r <= probe_nxt;
    aux_r   <= aux_nxt;
    prod_r  <= prod_nxt;
    res_r   <= res_nxt;
    level_r <= level_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/wrms_checker.sv =====
// Port-level checker for the window RMS unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wrms_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire                              in_ready,
  input  wire                              out_valid,
  input  wire                              out_ready,
  input  wire [wrms_pkg::LevelW-1:0]       out_rms_level
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rms_level))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready right after an accepted transaction");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result with no transaction outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many transactions outstanding");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind window_rms_from_sums_unit wrms_checker u_wrms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_rms_level (out_rms_level)
);
`default_nettype wire
